>>> hw/rtl/plwe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plwe_pkg
// Shared types and constants of the polyline length with error core.
// ----------------------------------------------------------------------------
package plwe_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int MAX_POINTS_DEF  = 256;
    localparam int LEN_W = 27;
    localparam int ERR_W = 42;
    localparam int LERR_W = 21;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        err_x;
        logic [15:0]        err_y;
        logic [15:0]        err_z;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic [LEN_W-1:0]  track_length;
        logic [LERR_W-1:0] length_error;
    } result_t;

endpackage
`default_nettype wire

>>> hw/rtl/plwe_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plwe_isqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module plwe_isqrt #(
    parameter int RW = 21
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [2*RW-1:0] radicand,
    output logic                 done,
    output logic [RW-1:0]        root
);
    localparam int CW = $clog2(RW + 1);

    logic [2*RW-1:0] rad_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;

    // Shift in two radicand bits, try subtracting 4*root+1.
    assign rem_sh = {rem_reg[RW-1:0], rad_reg[2*RW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    // Count iterations; flag done once the last root bit is stored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

>>> hw/rtl/polyline_length_with_error_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_length_with_error_core
// Streaming 3D track length with propagated per-axis error.
// ----------------------------------------------------------------------------
// Points arrive on the in channel (valid/stall), one beat per point. Each
// segment adds floor(sqrt(16*S)) quarter units of length when z changes and,
// when S is nonzero, floor(sum d^2*(ep^2+ec^2)/S) to the error sum. The beat
// marked last_point yields one result beat on the out channel: the saturated
// length and floor(sqrt(error sum)); then all state clears.
// A point passes a difference state, a square state per axis, a sum state,
// then for each of the three axes a root state and a serial multiply (one
// error-power bit per cycle), a restoring division and an accumulate
// state; the segment root runs beside the multiply. Stall stays high
// during that work, so a new point is accepted only once the previous one
// is through. A last point then runs the final root and the output state
// before its result is valid.
// Reset clears the previous point, both sums and the output register. A held
// result waits in the output register while out stall is high; the core goes
// on taking points, and a following result waits in the output state, with
// in stall high, until the held one leaves.
// ----------------------------------------------------------------------------
module polyline_length_with_error_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire plwe_pkg::point_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output plwe_pkg::result_t      out_data
);
    localparam int LW = plwe_pkg::LEN_W;
    localparam int EW = plwe_pkg::ERR_W;
    localparam int NW = 84;
    localparam int DW = 34;
    localparam logic [LW-1:0] LEN_MAX = '1;
    localparam logic [EW-1:0] ERR_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_SQ, S_SUMS, S_ROOT, S_MUL, S_DIV, S_ACC, S_FROOT, S_OUT
    } state_t;

    state_t state_reg;
    logic signed [16:0] px_reg, py_reg, pz_reg;
    logic [15:0] pex_reg, pey_reg, pez_reg;
    logic have_prev_reg;
    logic [LW-1:0] len_reg;
    logic [EW-1:0] err_reg;
    plwe_pkg::point_t cur_reg;
    logic [16:0] mag_reg [3];
    logic [33:0] dsq_reg [3];
    logic [32:0] esq_reg [3];
    logic [1:0]  ax_reg;
    logic [5:0]  bit_reg;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] prod_reg;
    logic [DW+1:0] s_reg;
    logic [NW-1:0] quo_reg;
    logic [DW+1:0] rem_reg;
    logic [6:0]  dcnt_reg;
    plwe_pkg::result_t out_reg;
    logic out_valid_reg;

    logic sq_start, sq_done;
    logic [41:0] sq_rad;
    logic [20:0] sq_root;

    logic signed [16:0] dx, dy, dz;
    logic [DW+2:0] rem_sh;
    logic [EW:0] err_add;
    logic [EW-1:0] err_upd;
    logic [DW+1:0] s_sum;
    logic [NW-1:0] prod_sh;

    plwe_isqrt #(.RW(21)) u_isqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_rad),
        .done(sq_done), .root(sq_root)
    );

    assign dx = 17'(cur_reg.pos_x) - px_reg;
    assign dy = 17'(cur_reg.pos_y) - py_reg;
    assign dz = 17'(cur_reg.pos_z) - pz_reg;
    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign err_add = {1'b0, err_reg} + {1'b0, quo_reg[EW-1:0]};
    assign s_sum = 36'(dsq_reg[0]) + 36'(dsq_reg[1]) + 36'(dsq_reg[2]);

    // next error sum, saturating
    assign err_upd = (have_prev_reg && s_reg != '0)
                   ? ((quo_reg[NW-1:EW] != '0 || err_add[EW]) ? ERR_MAX : err_add[EW-1:0])
                   : err_reg;

    // one Horner step of the current axis product
    assign prod_sh = esq_reg[ax_reg][6'd32 - bit_reg]
                   ? (prod_reg << 1) + NW'(dsq_reg[ax_reg])
                   : prod_reg << 1;

    assign sq_start = (state_reg == S_SUMS && have_prev_reg
                       && (cur_reg.pos_z != pz_reg[15:0]))
                   || (state_reg == S_ACC && cur_reg.last_point);
    assign sq_rad = (state_reg == S_SUMS) ? {4'b0, s_sum[DW-1:0], 4'b0} : err_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_prev_reg <= 1'b0;
            len_reg       <= '0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            px_reg <= '0; py_reg <= '0; pz_reg <= '0;
            pex_reg <= '0; pey_reg <= '0; pez_reg <= '0;
        end
        else
        begin
            // raise on a new result, drop once the beat leaves
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_DIFF;
                S_DIFF:
                begin
                    // take magnitudes of differences
                    mag_reg[0] <= dx[16] ? 17'(-dx) : 17'(dx);
                    mag_reg[1] <= dy[16] ? 17'(-dy) : 17'(dy);
                    mag_reg[2] <= dz[16] ? 17'(-dz) : 17'(dz);
                    ax_reg <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    // one axis a cycle: squares and error power sums
                    dsq_reg[ax_reg] <= 34'(mag_reg[ax_reg] * mag_reg[ax_reg]);
                    case (ax_reg)
                        2'd0: esq_reg[0] <= 33'(pex_reg * pex_reg)
                                          + 33'(cur_reg.err_x * cur_reg.err_x);
                        2'd1: esq_reg[1] <= 33'(pey_reg * pey_reg)
                                          + 33'(cur_reg.err_y * cur_reg.err_y);
                        default: esq_reg[2] <= 33'(pez_reg * pez_reg)
                                             + 33'(cur_reg.err_z * cur_reg.err_z);
                    endcase
                    if (ax_reg == 2'd2)
                        state_reg <= S_SUMS;
                    else
                        ax_reg <= ax_reg + 1'b1;
                end
                S_SUMS:
                begin
                    s_reg <= s_sum;
                    num_reg <= '0;
                    prod_reg <= '0;
                    ax_reg <= '0;
                    bit_reg <= '0;
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                    // the segment root runs beside the multiply and ends within it
                    state_reg <= S_MUL;
                S_MUL:
                begin
                    // serial multiply: one error-power bit per cycle
                    if (sq_done)
                        len_reg <= (len_reg + LW'(sq_root) < len_reg) ? LEN_MAX
                                 : len_reg + LW'(sq_root);
                    if (bit_reg == 6'd32)
                    begin
                        num_reg <= num_reg + prod_sh;
                        prod_reg <= '0;
                        bit_reg <= '0;
                        if (ax_reg == 2'd2)
                        begin
                            state_reg <= S_DIV;
                            dcnt_reg  <= '0;
                            rem_reg   <= '0;
                        end
                        else
                        begin
                            ax_reg <= ax_reg + 1'b1;
                            state_reg <= S_ROOT;
                        end
                    end
                    else
                    begin
                        prod_reg <= prod_sh;
                        bit_reg <= bit_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    // restoring divide, one quotient bit per cycle
                    num_reg <= num_reg << 1;
                    if (rem_sh >= {1'b0, s_reg})
                    begin
                        rem_reg <= 36'(rem_sh - {1'b0, s_reg});
                        quo_reg <= {quo_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[DW+1:0];
                        quo_reg <= {quo_reg[NW-2:0], 1'b0};
                    end
                    if (dcnt_reg == 7'(NW - 1))
                        state_reg <= S_ACC;
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                S_ACC:
                begin
                    err_reg <= err_upd;
                    px_reg <= 17'(cur_reg.pos_x);
                    py_reg <= 17'(cur_reg.pos_y);
                    pz_reg <= 17'(cur_reg.pos_z);
                    pex_reg <= cur_reg.err_x;
                    pey_reg <= cur_reg.err_y;
                    pez_reg <= cur_reg.err_z;
                    have_prev_reg <= 1'b1;
                    state_reg <= cur_reg.last_point ? S_FROOT : S_IDLE;
                end
                S_FROOT:
                    if (sq_done)
                        state_reg <= S_OUT;
                S_OUT:
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_reg.track_length <= len_reg;
                        out_reg.length_error <= sq_root;
                        have_prev_reg <= 1'b0;
                        len_reg <= '0;
                        err_reg <= '0;
                        px_reg <= '0; py_reg <= '0; pz_reg <= '0;
                        pex_reg <= '0; pey_reg <= '0; pez_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // capture the point beat
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            cur_reg <= in_data;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_sqrt_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_MUL || state_reg == S_ROOT || state_reg == S_FROOT))
        else $error("root finished outside its window");
    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside output state");
    a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> !have_prev_reg && len_reg == '0)
        else $error("state not cleared after result");

endmodule
`default_nettype wire
